@@ hw/rtl/mlrs_pkg.sv @@
// shared types and constants for the multi-lamp rhythm sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package mlrs_pkg;

	localparam int LAMPS_DEF      = 32;
	localparam int RHYTHMS_DEF    = 32;
	localparam int STEPS_DEF      = 16;
	localparam int MAX_TICK_LAMPS = 32;
	localparam int QDEPTH         = 2;

	typedef enum logic [1:0] {
		CMD_WSTEP = 2'd0,
		CMD_WLEN  = 2'd1,
		CMD_BIND  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_e_t;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] lamp_sel;
		logic [4:0] rhythm_sel;
		logic [3:0] step_sel;
		logic [7:0] step_color;
		logic [7:0] step_delay;
		logic [4:0] rhythm_length;
	} in_t;

	typedef struct packed {
		logic [4:0] lamp_id;
		logic [7:0] lamp_color;
		logic       last;
	} out_t;

	// classified command as it sits in the queue
	typedef struct packed {
		cmd_e_t     cmd;
		logic       ok;
		logic [4:0] lamp_sel;
		logic [4:0] rhythm_sel;
		logic [3:0] step_sel;
		logic [7:0] color;
		logic [7:0] delay;
		logic [4:0] length;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LRD,
		ST_TRD,
		ST_CMP,
		ST_COL,
		ST_END
	} back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/multi_lamp_rhythm_sequencer_top.sv @@
// top level of the multi-lamp rhythm sequencer
// depends on mlrs_pkg, mlrs_front, mlrs_queue, mlrs_back
`default_nettype none

// A command is taken at a clock edge with start high and busy low; busy rises only when
// the two-entry command queue is full. Write-step, write-length and bind commands retire
// in the executor's idle state, which pops each and does its write. A tick walks lamps 0
// to min(active_lamps, LAMPS, 32)-1; per lamp it does single-port registered reads of the
// lamp state and then of the step table, a compare, and a colour read if the lamp changes
// step. Each change transaction appears on result with result_strobe high for exactly
// one cycle and cannot be held off; each is delivered when the next change is found or at
// the end of the tick, where the final one carries last. A tick with no change gives no
// transaction. Write cfg_wdata with cfg_we only while idle.
module multi_lamp_rhythm_sequencer_top #(
	parameter int LAMPS   = mlrs_pkg::LAMPS_DEF,
	parameter int RHYTHMS = mlrs_pkg::RHYTHMS_DEF,
	parameter int STEPS   = mlrs_pkg::STEPS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire mlrs_pkg::in_t item,
	input  wire logic          cfg_we,
	input  wire logic [5:0]    cfg_wdata,
	output mlrs_pkg::out_t     result,
	output logic               result_strobe
);
	import mlrs_pkg::*;

	logic       q_full;
	logic       q_push;
	op_t        q_op;
	q_head_t    head;
	logic       pop;
	logic [5:0] active_lamps;

	mlrs_front #(
		.LAMPS(LAMPS),
		.RHYTHMS(RHYTHMS),
		.STEPS(STEPS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.active_lamps(active_lamps),
		.q_full(q_full),
		.q_push(q_push),
		.q_op(q_op)
	);

	mlrs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.op(q_op),
		.full(q_full),
		.pop(pop),
		.head(head)
	);

	mlrs_back #(
		.LAMPS(LAMPS),
		.RHYTHMS(RHYTHMS),
		.STEPS(STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.active_lamps(active_lamps),
		.result(result),
		.result_strobe(result_strobe)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mlrs_front.sv @@
// front end: takes commands, range-checks addresses, holds the active lamp count
// depends on mlrs_pkg
`default_nettype none

module mlrs_front #(
	parameter int LAMPS   = mlrs_pkg::LAMPS_DEF,
	parameter int RHYTHMS = mlrs_pkg::RHYTHMS_DEF,
	parameter int STEPS   = mlrs_pkg::STEPS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire mlrs_pkg::in_t item,
	output logic              busy,
	input  wire logic         cfg_we,
	input  wire logic [5:0]   cfg_wdata,
	output logic [5:0]        active_lamps,
	input  wire logic         q_full,
	output logic              q_push,
	output mlrs_pkg::op_t     q_op
);
	import mlrs_pkg::*;

	logic [5:0] active_lamps_q;
	logic       rh_ok;
	logic       st_ok;
	logic       lm_ok;
	cmd_e_t     cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_lamps_q <= 6'd0;
		end else if (cfg_we) begin
			active_lamps_q <= cfg_wdata;
		end
	end

	assign active_lamps = active_lamps_q;
	assign busy         = q_full;
	assign q_push       = start && !q_full;

	assign cmd   = cmd_e_t'(item.command);
	assign rh_ok = 32'(item.rhythm_sel) < RHYTHMS;
	assign st_ok = 32'(item.step_sel) < STEPS;
	assign lm_ok = 32'(item.lamp_sel) < LAMPS;

	always_comb begin
		q_op.cmd        = cmd;
		q_op.lamp_sel   = item.lamp_sel;
		q_op.rhythm_sel = item.rhythm_sel;
		q_op.step_sel   = item.step_sel;
		q_op.color      = item.step_color;
		q_op.delay      = item.step_delay;
		q_op.length     = item.rhythm_length;
		unique case (cmd)
			CMD_WSTEP: q_op.ok = rh_ok && st_ok;
			CMD_WLEN:  q_op.ok = rh_ok;
			CMD_BIND:  q_op.ok = rh_ok && lm_ok;
			CMD_TICK:  q_op.ok = 1'b1;
			default:   q_op.ok = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/mlrs_queue.sv @@
// short command queue between front end and executor
// depends on mlrs_pkg
`default_nettype none

module mlrs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mlrs_pkg::op_t op,
	output logic               full,
	input  wire logic          pop,
	output mlrs_pkg::q_head_t  head
);
	import mlrs_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = PW + 1;

	op_t           slot_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = cnt_q == CW'(QDEPTH);
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = cnt_q != '0;
	assign head.op    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mlrs_back.sv @@
// executor: table and lamp stores, tick walk over lamps, result output
// depends on mlrs_pkg
`default_nettype none

module mlrs_back #(
	parameter int LAMPS   = mlrs_pkg::LAMPS_DEF,
	parameter int RHYTHMS = mlrs_pkg::RHYTHMS_DEF,
	parameter int STEPS   = mlrs_pkg::STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mlrs_pkg::q_head_t head,
	output logic                   pop,
	input  wire logic [5:0]        active_lamps,
	output mlrs_pkg::out_t         result,
	output logic                   result_strobe
);
	import mlrs_pkg::*;

	localparam int LW  = (LAMPS > 1) ? $clog2(LAMPS) : 1;
	localparam int RW  = (RHYTHMS > 1) ? $clog2(RHYTHMS) : 1;
	localparam int SW  = $clog2(STEPS);
	localparam int AW  = $clog2(RHYTHMS * STEPS);
	localparam int LIM = (LAMPS < MAX_TICK_LAMPS) ? LAMPS : MAX_TICK_LAMPS;
	localparam int LCW = $clog2(LIM + 1);

	typedef struct packed {
		logic [RW-1:0] rh;
		logic [SW-1:0] step;
		logic [7:0]    cnt;
	} lamp_word_t;

	// stores
	logic [15:0]  tbl_mem [RHYTHMS * STEPS];
	logic [4:0]   len_mem [RHYTHMS];
	lamp_word_t   lmp_mem [LAMPS];
	logic [LAMPS-1:0] lvld_q;

	// read data registers
	logic [15:0]  trd_q;
	logic [4:0]   lenrd_q;
	lamp_word_t   lrd_q;
	logic         lrdv_q;

	back_state_t  state_q, state_d;
	logic [LCW-1:0] lamp_q;
	logic         pend_vld_q;
	logic [4:0]   pend_id_q;
	logic [7:0]   pend_col_q;
	out_t         res_q;
	logic         strobe_q;

	// control from the state machine
	logic         tbl_we, tbl_re, len_we, len_re, lmp_we, lmp_re;
	logic         bind_wr, tick_go, lamp_done, pend_set, emit, emit_last;

	// datapath
	logic [LCW-1:0] lim;
	logic [LCW-1:0] lamp_nx;
	logic [LW-1:0]  lamp_idx;
	logic [SW-1:0]  cur;
	logic [7:0]     cnt;
	logic [7:0]     cnt_inc;
	logic [7:0]     eff_len;
	logic [7:0]     nxt_w;
	logic [SW-1:0]  nxt;
	logic           adv;
	logic [RW-1:0]  a_rh;
	logic [SW-1:0]  a_st;
	logic [AW-1:0]  tbl_addr;
	logic [LW-1:0]  lmp_waddr;
	lamp_word_t     lmp_wdata;
	out_t           emit_data;

	assign lim      = (32'(active_lamps) > LIM) ? LCW'(LIM) : LCW'(active_lamps);
	assign lamp_nx  = lamp_q + LCW'(1);
	assign lamp_idx = lamp_q[LW-1:0];

	// a lamp never written reads as step 0, count 0
	assign cur     = lrdv_q ? lrd_q.step : '0;
	assign cnt     = lrdv_q ? lrd_q.cnt : 8'd0;
	assign cnt_inc = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
	assign adv     = cnt_inc >= trd_q[7:0];
	assign eff_len = (32'(lenrd_q) > STEPS) ? 8'(STEPS) : 8'(lenrd_q);
	assign nxt_w   = 8'(cur) + 8'd1;
	assign nxt     = (nxt_w >= eff_len) ? '0 : SW'(nxt_w);

	// one shared table address: write slot when idle, current step, then next step
	always_comb begin
		if (state_q == ST_IDLE) begin
			a_rh = RW'(head.op.rhythm_sel);
			a_st = SW'(head.op.step_sel);
		end else begin
			a_rh = lrd_q.rh;
			a_st = (state_q == ST_CMP) ? nxt : cur;
		end
	end

	assign tbl_addr = AW'(32'(a_rh) * STEPS + 32'(a_st));

	always_comb begin
		if (bind_wr) begin
			lmp_waddr      = LW'(head.op.lamp_sel);
			lmp_wdata.rh   = RW'(head.op.rhythm_sel);
			lmp_wdata.step = '0;
			lmp_wdata.cnt  = 8'd0;
		end else begin
			lmp_waddr      = lamp_idx;
			lmp_wdata.rh   = lrd_q.rh;
			lmp_wdata.step = adv ? nxt : cur;
			lmp_wdata.cnt  = adv ? 8'd0 : cnt_inc;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		len_we    = 1'b0;
		len_re    = 1'b0;
		lmp_we    = 1'b0;
		lmp_re    = 1'b0;
		bind_wr   = 1'b0;
		tick_go   = 1'b0;
		lamp_done = 1'b0;
		pend_set  = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.op.cmd)
						CMD_WSTEP: tbl_we = head.op.ok;
						CMD_WLEN:  len_we = head.op.ok;
						CMD_BIND: begin
							lmp_we  = head.op.ok;
							bind_wr = 1'b1;
						end
						CMD_TICK: begin
							tick_go = 1'b1;
							state_d = (lim == '0) ? ST_END : ST_LRD;
						end
						default: ;
					endcase
				end
			end
			ST_LRD: begin
				lmp_re  = 1'b1;
				state_d = ST_TRD;
			end
			ST_TRD: begin
				tbl_re  = 1'b1;
				len_re  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				lmp_we = 1'b1;
				if (adv) begin
					tbl_re  = 1'b1;
					state_d = ST_COL;
				end else begin
					lamp_done = 1'b1;
				end
			end
			ST_COL: begin
				// the held result is not the last one, a newer one replaces it
				emit      = pend_vld_q;
				pend_set  = 1'b1;
				lamp_done = 1'b1;
			end
			ST_END: begin
				emit      = pend_vld_q;
				emit_last = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (lamp_done) begin
			state_d = (lamp_nx == lim) ? ST_END : ST_LRD;
		end
	end

	assign emit_data.lamp_id    = pend_id_q;
	assign emit_data.lamp_color = pend_col_q;
	assign emit_data.last       = emit_last;

	// memories
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_addr] <= {head.op.color, head.op.delay};
		end
		if (tbl_re) begin
			trd_q <= tbl_mem[tbl_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[a_rh] <= head.op.length;
		end
		if (len_re) begin
			lenrd_q <= len_mem[a_rh];
		end
	end

	always_ff @(posedge clk) begin
		if (lmp_we) begin
			lmp_mem[lmp_waddr] <= lmp_wdata;
		end
		if (lmp_re) begin
			lrd_q  <= lmp_mem[lamp_idx];
			lrdv_q <= lvld_q[lamp_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lamp_q     <= '0;
			lvld_q     <= '0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (lmp_we) begin
				lvld_q[lmp_waddr] <= 1'b1;
			end
			if (tick_go) begin
				lamp_q <= '0;
			end else if (lamp_done) begin
				lamp_q <= lamp_nx;
			end
			if (pend_set) begin
				pend_vld_q <= 1'b1;
			end else if (emit_last) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_set) begin
			pend_id_q  <= 5'(lamp_idx);
			pend_col_q <= trd_q[15:8];
		end
		if (emit) begin
			res_q <= emit_data;
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire
